@@ sv/sbmq_pkg.sv @@
// Shared definitions for the shared-buffer multi-queue: sizes, codes, command record.
`timescale 1ns / 1ps
`default_nettype none
package sbmq_pkg;

    localparam int ENTRIES  = 64;
    localparam int QUEUES   = 8;
    localparam int ADDR_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int Q_IDX_W  = $clog2(QUEUES);
    localparam int QID_W    = 3;
    localparam int DATA_W   = 32;
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic                op;
        logic [Q_IDX_W-1:0]  qidx;
        logic [DATA_W-1:0]   item;
        status_t             status;
        logic                last;       // dequeue takes the only entry of the queue
        logic                was_empty;  // enqueue into an empty queue
    } cmd_t;

endpackage
`default_nettype wire

@@ sv/sbmq_front.sv @@
// Front end: accepts commands, checks them against occupancy counts, emits classified commands.
`timescale 1ns / 1ps
`default_nettype none
module sbmq_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        operation,
    input  wire logic [sbmq_pkg::QID_W-1:0]  queue_id,
    input  wire logic signed [31:0]          item,
    output logic                             push,
    output sbmq_pkg::cmd_t                   cmd
);
    import sbmq_pkg::*;

    logic [CNT_W-1:0]   free_count_reg;
    logic [CNT_W-1:0]   qcount_reg [QUEUES];
    logic [Q_IDX_W-1:0] qidx;
    logic               in_range;
    logic [CNT_W-1:0]   qcnt;

    assign push     = start && !busy;
    assign qidx     = queue_id[Q_IDX_W-1:0];
    assign in_range = int'(queue_id) < QUEUES;
    assign qcnt     = qcount_reg[qidx];

    always_comb
    begin
        cmd.op        = operation;
        cmd.qidx      = qidx;
        cmd.item      = item;
        cmd.last      = (qcnt == CNT_W'(1));
        cmd.was_empty = (qcnt == '0);
        if (operation == OP_ENQ)
        begin
            cmd.status = (in_range && free_count_reg != '0) ? ST_OK : ST_FULL;
        end
        else
        begin
            cmd.status = (in_range && qcnt != '0) ? ST_OK : ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= CNT_W'(ENTRIES);
            for (int i = 0; i < QUEUES; i++)
            begin
                qcount_reg[i] <= '0;
            end
        end
        else if (push && cmd.status == ST_OK)
        begin
            if (operation == OP_ENQ)
            begin
                free_count_reg   <= free_count_reg - CNT_W'(1);
                qcount_reg[qidx] <= qcnt + CNT_W'(1);
            end
            else
            begin
                free_count_reg   <= free_count_reg + CNT_W'(1);
                qcount_reg[qidx] <= qcnt - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/sbmq_cmd_fifo.sv @@
// Short command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module sbmq_cmd_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sbmq_pkg::cmd_t  push_cmd,
    input  wire logic            pop,
    output logic                 valid,
    output sbmq_pkg::cmd_t       head_cmd
);
    import sbmq_pkg::*;

    cmd_t                slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_CNT_W-1:0] count_reg;

    assign valid    = (count_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CQ_CNT_W'(push) - CQ_CNT_W'(pop && valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ sv/sbmq_back.sv @@
// Back end: entry store, link memory and list pointers; carries out classified commands.
`timescale 1ns / 1ps
`default_nettype none
module sbmq_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire sbmq_pkg::cmd_t  cmd,
    output logic                 cmd_pop,
    output logic                 busy,
    output logic                 done,
    output logic signed [31:0]   item_out,
    output logic [1:0]           status
);
    import sbmq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [ADDR_W-1:0]   free_head_reg;
    logic [ADDR_W-1:0]   head_reg [QUEUES];
    logic [ADDR_W-1:0]   tail_reg [QUEUES];
    logic [ENTRIES-1:0]  link_valid_reg;
    logic [ADDR_W-1:0]   link_mem [ENTRIES];
    logic [DATA_W-1:0]   data_mem [ENTRIES];
    logic [ADDR_W-1:0]   link_rd_reg;
    logic                link_rd_valid_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [DATA_W-1:0]   data_rd_reg;
    logic                done_reg;
    logic [DATA_W-1:0]   item_out_reg;
    status_t             status_reg;

    logic                issue;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   link_q;
    logic                link_we;
    logic [ADDR_W-1:0]   link_wa;
    logic [ADDR_W-1:0]   link_wd;
    logic                exec_enq;

    // Initial free chain: entry i links to i+1, last wraps to 0.
    function automatic logic [ADDR_W-1:0] reset_link(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] n;
        n = (a == ADDR_W'(ENTRIES - 1)) ? '0 : a + ADDR_W'(1);
        return n;
    endfunction

    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign issue    = cmd_pop && (cmd.status == ST_OK);
    assign rd_addr  = (cmd.op == OP_ENQ) ? free_head_reg : head_reg[cmd.qidx];
    assign link_q   = link_rd_valid_reg ? link_rd_reg : reset_link(rd_addr_reg);
    assign exec_enq = (cmd_reg.op == OP_ENQ);

    assign link_we  = (state_reg == S_EXEC) && (!exec_enq || !cmd_reg.was_empty);
    assign link_wa  = exec_enq ? tail_reg[cmd_reg.qidx] : rd_addr_reg;
    assign link_wd  = exec_enq ? rd_addr_reg : free_head_reg;

    assign busy     = (state_reg == S_EXEC);
    assign done     = done_reg;
    assign item_out = item_out_reg;
    assign status   = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            free_head_reg     <= '0;
            link_valid_reg    <= '0;
            link_rd_valid_reg <= 1'b0;
            done_reg          <= 1'b0;
            item_out_reg      <= '0;
            status_reg        <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (link_we)
            begin
                link_valid_reg[link_wa] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (issue)
                    begin
                        link_rd_valid_reg <= link_valid_reg[rd_addr];
                        state_reg         <= S_EXEC;
                    end
                    else if (cmd_pop)
                    begin
                        // refused: answer at once
                        done_reg     <= 1'b1;
                        item_out_reg <= '0;
                        status_reg   <= cmd.status;
                    end
                end
                S_EXEC:
                begin
                    free_head_reg <= exec_enq ? link_q : rd_addr_reg;
                    done_reg      <= 1'b1;
                    item_out_reg  <= exec_enq ? '0 : data_rd_reg;
                    status_reg    <= ST_OK;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Command copy and queue pointers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (issue)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (state_reg == S_EXEC)
        begin
            if (exec_enq)
            begin
                tail_reg[cmd_reg.qidx] <= rd_addr_reg;
                if (cmd_reg.was_empty)
                begin
                    head_reg[cmd_reg.qidx] <= rd_addr_reg;
                end
            end
            else if (!cmd_reg.last)
            begin
                head_reg[cmd_reg.qidx] <= link_q;
            end
        end
    end

    // Link and data memories: one read port, one write port each
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            link_rd_reg <= link_mem[rd_addr];
            data_rd_reg <= data_mem[rd_addr];
        end
        if (issue && cmd.op == OP_ENQ)
        begin
            data_mem[rd_addr] <= cmd.item;
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
    end

endmodule
`default_nettype wire

@@ sv/shared_buffer_multi_queue_top.sv @@
// Top level of the shared-buffer multi-queue.
`timescale 1ns / 1ps
`default_nettype none
// Eight FIFO queues share one store of 64 entries, kept as linked lists
// with a linked free list. A command (operation 0 enqueue item into
// queue_id, 1 dequeue from queue_id) is taken at a rising edge with start
// high and busy low. Exactly one result follows for every command: done is
// high for one cycle with item_out and status valid, and the receiver must
// take it then, since nothing here can wait. status is 0 ok, 1 queue empty
// on dequeue, 2 store full on enqueue; item_out is the dequeued word on a
// good dequeue and 0 otherwise. A good command passes through the command
// queue, then a read of the link and data memories, then a write of the
// link memory and pointers; a refused command is answered as it leaves the
// command queue, with no memory access. busy falls in the done cycle, so a
// new command may be taken then and not before. The front end checks each
// command against occupancy counts and passes it through a two-deep command
// queue to the back end, which owns the entry store. No clearing pass after
// reset: link entries carry valid bits and read as the initial free chain
// until first written.
module shared_buffer_multi_queue_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        operation,
    input  wire logic [sbmq_pkg::QID_W-1:0]  queue_id,
    input  wire logic signed [31:0]          item,
    output logic                             done,
    output logic signed [31:0]               item_out,
    output logic [1:0]                       status
);
    import sbmq_pkg::*;

    logic push;
    cmd_t front_cmd;
    logic fifo_valid;
    cmd_t fifo_cmd;
    logic back_pop;
    logic back_busy;

    // Busy covers a command anywhere between transfer and result.
    assign busy = fifo_valid || back_busy;

    sbmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .queue_id  (queue_id),
        .item      (item),
        .push      (push),
        .cmd       (front_cmd)
    );

    sbmq_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (back_pop),
        .valid    (fifo_valid),
        .head_cmd (fifo_cmd)
    );

    sbmq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (fifo_valid),
        .cmd       (fifo_cmd),
        .cmd_pop   (back_pop),
        .busy      (back_busy),
        .done      (done),
        .item_out  (item_out),
        .status    (status)
    );

endmodule
`default_nettype wire

@@ sv/sbmq_checker.sv @@
// Port-level checks for the shared-buffer multi-queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbmq_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        done,
    input  wire logic signed [31:0]          item_out,
    input  wire logic [1:0]                  status
);
    import sbmq_pkg::*;

    // A transfer keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a transfer");

    // A result only follows a cycle in which a command was in flight.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result with no command in flight");

    // One command at a time: strobes never come back to back.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result strobes in a row");

    // Status is a known code, and refusals carry a zero word.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
        else $error("unknown status code");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (item_out == '0))
        else $error("refused command returned a nonzero word");

endmodule

bind shared_buffer_multi_queue_top sbmq_checker u_sbmq_checker (.*);
`default_nettype wire

@@ verif/tb_shared_buffer_multi_queue_top.sv @@
// Self-checking testbench for the shared-buffer multi-queue top level.
`timescale 1ns / 1ps
module tb_shared_buffer_multi_queue_top;
    import sbmq_pkg::*;

    // One expected completion: the dequeued word and the status code.
    typedef struct {
        logic signed [DATA_W-1:0] word;
        status_t                  st;
    } outcome_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic [QID_W-1:0]         queue_id;
    logic signed [31:0]       item;
    logic                     done;
    logic signed [31:0]       item_out;
    logic [1:0]               status;

    // Shadow copy of the entry store, queue lists and free list.
    logic [DATA_W-1:0]        slot_word [ENTRIES];
    logic [ADDR_W-1:0]        slot_next [ENTRIES];
    logic [ADDR_W-1:0]        q_first   [QUEUES];
    logic [ADDR_W-1:0]        q_last    [QUEUES];
    logic                     q_vacant  [QUEUES];
    logic [ADDR_W-1:0]        spare_head;
    int                       spare_count;

    outcome_t                 pending_outcomes[$];
    outcome_t                 want;

    int                       send_idle_pct;
    int                       mismatches;
    int                       transfers;
    int                       good_dequeues;
    int                       empty_refusals;
    int                       full_refusals;

    shared_buffer_multi_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .queue_id  (queue_id),
        .item      (item),
        .done      (done),
        .item_out  (item_out),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_outcomes.size());
        $display("== FAIL ==");
        $finish;
    end

    // Shadow model: applies one command and returns the completion it must give.
    function automatic void apply_command(input logic op, input logic [QID_W-1:0] qn,
                                          input logic [DATA_W-1:0] data,
                                          output outcome_t res);
        logic [ADDR_W-1:0] slot;
        res.word = '0;
        res.st   = ST_OK;
        if (op == OP_ENQ) begin
            if (int'(qn) >= QUEUES || spare_count == 0) begin
                res.st = ST_FULL;
            end else begin
                slot            = spare_head;
                spare_head      = slot_next[slot];
                spare_count     = spare_count - 1;
                slot_word[slot] = data;
                if (q_vacant[qn]) begin
                    q_first[qn]  = slot;
                    q_vacant[qn] = 1'b0;
                end else begin
                    // append behind the current tail
                    slot_next[q_last[qn]] = slot;
                end
                q_last[qn] = slot;
            end
        end else begin
            if (int'(qn) >= QUEUES || q_vacant[qn]) begin
                res.st = ST_EMPTY;
            end else begin
                slot     = q_first[qn];
                res.word = slot_word[slot];
                // tail link is stale, so emptiness comes from the head/tail match
                if (slot == q_last[qn])
                    q_vacant[qn] = 1'b1;
                else
                    q_first[qn] = slot_next[slot];
                slot_next[slot] = spare_head;
                spare_head      = slot;
                spare_count     = spare_count + 1;
            end
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("MISMATCH at %0t: %s got 0x%08h expected 0x%08h", $time, what, got, exp_val);
        mismatches++;
    endtask

    // Completion checker: done can never be held off, so every strobe is consumed.
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (pending_outcomes.size() == 0) begin
                flag_mismatch("unexpected completion, item_out", item_out, '0);
            end else begin
                want = pending_outcomes.pop_front();
                if (item_out !== want.word)
                    flag_mismatch("item_out", item_out, want.word);
                if (status !== want.st)
                    flag_mismatch("status", {30'd0, status}, {30'd0, want.st});
                case (want.st)
                    ST_EMPTY: empty_refusals++;
                    ST_FULL:  full_refusals++;
                    default:  if (want.word !== 'x) good_dequeues += 0;
                endcase
            end
        end
    end

    // One command transfer. Fields change on the falling edge; the transfer
    // happens at the first rising edge that sees busy low.
    task automatic issue_command(input logic op, input logic [QID_W-1:0] qn,
                                 input logic [31:0] data);
        int       gap;
        outcome_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            start <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        queue_id  <= qn;
        item      <= data;
        do
            @(posedge clk);
        while (busy);
        apply_command(op, qn, data, res);
        if (op == OP_DEQ && res.st == ST_OK)
            good_dequeues++;
        pending_outcomes.insert(pending_outcomes.size(), res);
        transfers++;
    endtask

    task automatic wait_for_results();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic release_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Extremes of the data word, every queue, refusal on empty, single-entry drain.
    task automatic test_directed();
        issue_command(OP_DEQ, 3'd0, 32'h1234_5678);   // empty queue, word ignored
        issue_command(OP_DEQ, 3'd7, 32'hFFFF_FFFF);
        issue_command(OP_ENQ, 3'd0, 32'h7FFF_FFFF);   // enqueue into empty queue
        issue_command(OP_ENQ, 3'd0, 32'h8000_0000);
        issue_command(OP_ENQ, 3'd7, 32'h0000_0000);
        issue_command(OP_ENQ, 3'd7, 32'hFFFF_FFFF);
        issue_command(OP_ENQ, 3'd3, 32'h5555_5555);
        issue_command(OP_ENQ, 3'd4, 32'hAAAA_AAAA);
        issue_command(OP_DEQ, 3'd0, 32'h0);
        issue_command(OP_DEQ, 3'd0, 32'h0);           // takes the last entry
        issue_command(OP_DEQ, 3'd0, 32'h0);           // now empty again
        issue_command(OP_DEQ, 3'd7, 32'h0);
        issue_command(OP_DEQ, 3'd7, 32'h0);
        issue_command(OP_DEQ, 3'd3, 32'h0);
        issue_command(OP_DEQ, 3'd4, 32'h0);
        issue_command(OP_DEQ, 3'd4, 32'h0);
        issue_command(OP_ENQ, 3'd1, 32'h0000_0001);
        issue_command(OP_ENQ, 3'd2, 32'hFFFF_FFFE);
        issue_command(OP_ENQ, 3'd5, 32'h0F0F_0F0F);
        issue_command(OP_ENQ, 3'd6, 32'hF0F0_F0F0);
        issue_command(OP_DEQ, 3'd6, 32'h0);
        issue_command(OP_DEQ, 3'd5, 32'h0);
        issue_command(OP_DEQ, 3'd2, 32'h0);
        issue_command(OP_DEQ, 3'd1, 32'h0);
    endtask

    // Fill the whole store, bounce off it, then drain every queue dry.
    task automatic test_store_full();
        int               k;
        logic [QID_W-1:0] qn;
        while (spare_count > 0)
            issue_command(OP_ENQ, QID_W'($urandom_range(QUEUES - 1)), $urandom());
        // sender holds off until the store is quiet
        release_start();
        wait_for_results();
        for (k = 0; k < 4; k++)
            issue_command(OP_ENQ, QID_W'($urandom_range(QUEUES - 1)), $urandom());
        for (k = 0; k < QUEUES; k++) begin
            qn = QID_W'(k);
            while (!q_vacant[qn])
                issue_command(OP_DEQ, qn, $urandom());
            issue_command(OP_DEQ, qn, $urandom());
        end
    endtask

    // Random traffic in 48-item chunks: two fill-heavy chunks then two
    // drain-heavy ones, so the store hits full and the queues run dry.
    task automatic test_random_traffic(input int count, input int idle_pct);
        int               k;
        int               enq_pct;
        int               tries;
        logic             op;
        logic [QID_W-1:0] qn;
        send_idle_pct = idle_pct;
        for (k = 0; k < count; k++) begin
            enq_pct = (((k / 48) % 4) < 2) ? 90 : 20;
            op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            // half the time crowd two queues so lists get long and interleaved
            if ($urandom_range(1) == 1)
                qn = QID_W'($urandom_range(1));
            else
                qn = QID_W'($urandom_range(QUEUES - 1));
            if (op == OP_DEQ && $urandom_range(99) < 80) begin
                tries = 0;
                while (q_vacant[qn] && tries < 16) begin
                    qn = QID_W'($urandom_range(QUEUES - 1));
                    tries++;
                end
            end
            issue_command(op, qn, $urandom());
        end
    endtask

    initial
    begin
        int k;
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_ENQ;
        queue_id  = '0;
        item      = '0;
        mismatches     = 0;
        transfers      = 0;
        good_dequeues  = 0;
        empty_refusals = 0;
        full_refusals  = 0;
        send_idle_pct  = 38;
        for (k = 0; k < ENTRIES; k++) begin
            slot_word[k] = '0;
            slot_next[k] = ADDR_W'((k + 1) % ENTRIES);
        end
        for (k = 0; k < QUEUES; k++) begin
            q_first[k]  = '0;
            q_last[k]   = '0;
            q_vacant[k] = 1'b1;
        end
        spare_head  = '0;
        spare_count = ENTRIES;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_store_full();
        test_random_traffic(330, 38);
        test_random_traffic(330, 81);
        test_random_traffic(330, 0);

        release_start();
        wait_for_results();
        repeat (8) @(posedge clk);

        $display("Run covered %0d transfers over three sender idle mixes:", transfers);
        $display("  %0d good dequeues, %0d empty-queue refusals, %0d store-full refusals",
                 good_dequeues, empty_refusals, full_refusals);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
